FILE: rtl/efr_pkg.sv
// Shared types and constants for the error-flag registry.
// Holds the request codes, the fixed field widths and the controller command struct.
// No dependencies.
package efr_pkg;

    localparam int REQ_W     = 2;
    localparam int IDX_W     = 4;
    localparam int OUT_CNT_W = 16;
    localparam int MASK_W    = 16;

    localparam logic [REQ_W-1:0] REQ_SET    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REINIT = 2'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the request and start the counter read
        logic exec;   // apply the request and register the result
    } t_cmd;

endpackage

FILE: rtl/efr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-flag occurrence counters; no dependencies.
module efr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/efr_ctrl.sv
// Controller for the error-flag registry: a two-state sequencer and the result strobe.
// Depends on efr_pkg for the command struct.
module efr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output logic          o_strobe,
    output efr_pkg::t_cmd o_cmd
);
    import efr_pkg::*;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_EXEC = 1'b1;

    logic [0:0] r_state;
    logic [0:0] n_state;
    logic       r_strobe;
    t_cmd       w_cmd;

    always_comb begin
        n_state   = r_state;
        w_cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    w_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                w_cmd.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_cmd.exec;
        end
    end

    assign o_busy   = (r_state == ST_EXEC);
    assign o_strobe = r_strobe;
    assign o_cmd    = w_cmd;

    a_start_leads_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == ST_IDLE) |=> (r_state == ST_EXEC))
        else $error("accepted request did not move the controller to execute");

    a_strobe_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == ST_IDLE))
        else $error("result strobe raised while a request is still executing");

    a_no_back_to_back_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe held for more than one cycle");

endmodule

FILE: rtl/efr_dp.sv
// Datapath of the error-flag registry: flags, overall error, counters and result registers.
// Depends on efr_pkg and instantiates efr_ram for the per-flag counters.
module efr_dp #(
    parameter int NUM_ENTRIES = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  efr_pkg::t_cmd                  i_cmd,
    input  logic [efr_pkg::REQ_W-1:0]      i_req_type,
    input  logic [efr_pkg::IDX_W-1:0]      i_flag_index,
    input  logic                           i_cfg_we,
    input  logic [efr_pkg::MASK_W-1:0]     i_cfg_wdata,
    output logic                           o_accepted,
    output logic                           o_flag_state,
    output logic                           o_flag_enabled,
    output logic [efr_pkg::OUT_CNT_W-1:0]  o_flag_count,
    output logic                           o_overall_active,
    output logic [efr_pkg::IDX_W-1:0]      o_overall_index,
    output logic [efr_pkg::OUT_CNT_W-1:0]  o_overall_count
);
    import efr_pkg::*;

    localparam int AW = $clog2(NUM_ENTRIES);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // Architectural state
    logic [MASK_W-1:0]      r_mask;
    logic [NUM_ENTRIES-1:0] r_flags;
    logic [NUM_ENTRIES-1:0] r_cnt_valid;
    logic                   r_ov_valid;
    logic [IDX_W-1:0]       r_ov_src;
    logic [COUNT_WIDTH-1:0] r_ov_cnt;

    // Captured request
    logic [REQ_W-1:0]       r_req;
    logic [IDX_W-1:0]       r_idx;

    // Result registers
    logic                   r_out_acc;
    logic                   r_out_state;
    logic                   r_out_en;
    logic [OUT_CNT_W-1:0]   r_out_cnt;

    logic [NUM_ENTRIES-1:0] n_flags;
    logic [NUM_ENTRIES-1:0] n_cnt_valid;
    logic                   n_ov_valid;
    logic [IDX_W-1:0]       n_ov_src;
    logic [COUNT_WIDTH-1:0] n_ov_cnt;
    logic                   n_acc;
    logic                   n_state_bit;
    logic                   n_en;
    logic [COUNT_WIDTH-1:0] n_entry_cnt;

    logic [AW-1:0]          w_addr;
    logic [COUNT_WIDTH-1:0] w_rdata;
    logic [COUNT_WIDTH-1:0] w_cnt_rd;
    logic [COUNT_WIDTH-1:0] w_cnt_new;
    logic                   w_in_range;
    logic                   w_flag_ok;
    logic                   w_set_ok;
    logic [NUM_ENTRIES-1:0] w_left;
    logic [AW-1:0]          w_found;
    logic                   w_found_any;

    efr_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_ENTRIES)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_set_ok),
        .i_waddr (w_addr),
        .i_wdata (w_cnt_new),
        .i_re    (i_cmd.load),
        .i_raddr (AW'(i_flag_index)),
        .o_rdata (w_rdata)
    );

    assign w_addr     = AW'(r_idx);
    assign w_in_range = ({28'd0, r_idx} < 32'(NUM_ENTRIES));
    assign w_flag_ok  = w_in_range && (r_idx != '0);
    // A counter never written since reset or reinit reads as zero.
    assign w_cnt_rd   = r_cnt_valid[w_addr] ? w_rdata : '0;
    assign w_cnt_new  = (w_cnt_rd == CNT_MAX) ? w_cnt_rd : w_cnt_rd + 1'b1;
    assign w_set_ok   = i_cmd.exec && (r_req == REQ_SET) && w_flag_ok && r_mask[0]
                        && r_mask[r_idx] && !r_flags[w_addr];

    // Lowest-numbered flag left latched once the addressed one is dropped.
    always_comb begin
        w_left         = r_flags;
        w_left[w_addr] = 1'b0;
        w_found        = '0;
        w_found_any    = 1'b0;
        for (int k = NUM_ENTRIES - 1; k >= 1; k--) begin
            if (w_left[k]) begin
                w_found     = AW'(k);
                w_found_any = 1'b1;
            end
        end
    end

    always_comb begin
        n_flags     = r_flags;
        n_cnt_valid = r_cnt_valid;
        n_ov_valid  = r_ov_valid;
        n_ov_src    = r_ov_src;
        n_ov_cnt    = r_ov_cnt;
        n_acc       = w_in_range;
        n_entry_cnt = w_cnt_rd;
        case (r_req)
            REQ_SET: begin
                n_acc = w_set_ok;
                if (w_set_ok) begin
                    n_flags[w_addr]     = 1'b1;
                    n_cnt_valid[w_addr] = 1'b1;
                    n_entry_cnt         = w_cnt_new;
                    if (!r_ov_valid) begin
                        n_ov_valid = 1'b1;
                        n_ov_src   = r_idx;
                        n_ov_cnt   = (r_ov_cnt == CNT_MAX) ? r_ov_cnt : r_ov_cnt + 1'b1;
                    end
                end
            end
            REQ_CLEAR: begin
                n_acc = w_flag_ok;
                if (w_flag_ok && r_flags[w_addr]) begin
                    n_flags = w_left;
                    if (!w_found_any) begin
                        n_ov_valid = 1'b0;
                        n_ov_src   = '0;
                    end else if (!r_ov_valid || (r_ov_src != IDX_W'(w_found))) begin
                        n_ov_valid = 1'b1;
                        n_ov_src   = IDX_W'(w_found);
                        n_ov_cnt   = (r_ov_cnt == CNT_MAX) ? r_ov_cnt : r_ov_cnt + 1'b1;
                    end
                end
            end
            REQ_REINIT: begin
                n_flags     = '0;
                n_cnt_valid = '0;
                n_ov_valid  = 1'b0;
                n_ov_src    = '0;
                n_ov_cnt    = '0;
                n_entry_cnt = '0;
            end
            REQ_QUERY: begin
                n_acc = w_in_range;
            end
            default: begin
                n_acc = w_in_range;
            end
        endcase

        // Entry 0 reports the overall error in place of a flag.
        if (r_idx == '0) begin
            n_state_bit = n_ov_valid;
            n_entry_cnt = n_ov_cnt;
        end else begin
            n_state_bit = n_flags[w_addr];
        end
        n_en = r_mask[r_idx];
        if (!w_in_range) begin
            n_state_bit = 1'b0;
            n_en        = 1'b0;
            n_entry_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '1;
            r_flags     <= '0;
            r_cnt_valid <= '0;
            r_ov_valid  <= 1'b0;
            r_ov_src    <= '0;
            r_ov_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_flags     <= n_flags;
                r_cnt_valid <= n_cnt_valid;
                r_ov_valid  <= n_ov_valid;
                r_ov_src    <= n_ov_src;
                r_ov_cnt    <= n_ov_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_idx <= i_flag_index;
        end
        if (i_cmd.exec) begin
            r_out_acc   <= n_acc;
            r_out_state <= n_state_bit;
            r_out_en    <= n_en;
            r_out_cnt   <= OUT_CNT_W'(n_entry_cnt);
        end
    end

    assign o_accepted       = r_out_acc;
    assign o_flag_state     = r_out_state;
    assign o_flag_enabled   = r_out_en;
    assign o_flag_count     = r_out_cnt;
    assign o_overall_active = r_ov_valid;
    assign o_overall_index  = r_ov_src;
    assign o_overall_count  = OUT_CNT_W'(r_ov_cnt);

    a_source_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov_valid |-> r_flags[AW'(r_ov_src)])
        else $error("overall error points at a flag that is not latched");

    a_idle_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ov_valid |-> (r_flags == '0 && r_ov_src == '0))
        else $error("flags latched or source kept without an overall error");

    a_entry0_never_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_flags[0])
        else $error("overall entry latched as an individual flag");

endmodule

FILE: rtl/error_flag_registry_unit.sv
// Top level of the error-flag registry.
// Depends on efr_pkg; instantiates efr_ctrl (sequencer) and efr_dp (state and counters).
//
// Usage:
//   A request beat (i_req_type, i_flag_index) is taken at a rising edge where i_start is
//   high and o_busy is low. o_busy is high from that edge onward while the
//   request executes, so a new request cannot enter until the current one has executed.
//   The result beat appears on the o_* result ports, marked by o_strobe for exactly one
//   cycle, in the cycle after the execute edge.
//   The receiver cannot hold results off; each strobed beat must be taken as it comes.
//   That spacing is set by the counter RAM's registered read: the counter is read at the
//   accepting edge and written back with the rest of the state at the execute edge.
//   The enable mask is written through i_cfg_we / i_cfg_wdata at any edge where the
//   write enable is high; writes are meant only while no request is in flight.
//   Synchronous reset (i_rst_n low) clears all flags, counters and the overall error,
//   sets the enable mask to all ones and leaves the block idle with no strobe pending.
//   o_overall_active, o_overall_index and o_overall_count always show the live state.
module error_flag_registry_unit #(
    parameter int NUM_ENTRIES = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [efr_pkg::REQ_W-1:0]      i_req_type,
    input  logic [efr_pkg::IDX_W-1:0]      i_flag_index,
    input  logic                           i_cfg_we,
    input  logic [efr_pkg::MASK_W-1:0]     i_cfg_wdata,
    output logic                           o_strobe,
    output logic                           o_accepted,
    output logic                           o_flag_state,
    output logic                           o_flag_enabled,
    output logic [efr_pkg::OUT_CNT_W-1:0]  o_flag_count,
    output logic                           o_overall_active,
    output logic [efr_pkg::IDX_W-1:0]      o_overall_index,
    output logic [efr_pkg::OUT_CNT_W-1:0]  o_overall_count
);
    import efr_pkg::*;

    t_cmd w_cmd;

    efr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_cmd    (w_cmd)
    );

    efr_dp #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_req_type       (i_req_type),
        .i_flag_index     (i_flag_index),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_accepted       (o_accepted),
        .o_flag_state     (o_flag_state),
        .o_flag_enabled   (o_flag_enabled),
        .o_flag_count     (o_flag_count),
        .o_overall_active (o_overall_active),
        .o_overall_index  (o_overall_index),
        .o_overall_count  (o_overall_count)
    );

endmodule

FILE: test/error_flag_registry_unit_tb.sv
// Self-checking testbench for error_flag_registry_unit: a directed plan and random traffic
// under three sender idling profiles, all checked beat by beat.
// Depends on efr_pkg and the error_flag_registry_unit RTL.
module error_flag_registry_unit_tb;

    import efr_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int CYCLE_LIMIT = 100_000;
    localparam int SEG_ITEMS   = 288;

    typedef struct packed {
        logic                 accepted;
        logic                 state;
        logic                 enabled;
        logic [OUT_CNT_W-1:0] count;
        logic                 ov_active;
        logic [IDX_W-1:0]     ov_index;
        logic [OUT_CNT_W-1:0] ov_count;
    } t_registry_result;

    typedef struct {
        bit               is_cfg;
        logic [MASK_W-1:0] mask;
        logic [REQ_W-1:0] req;
        logic [IDX_W-1:0] idx;
        bit               typed;
        t_registry_result want;
    } t_plan_step;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_start      = 1'b0;
    logic [REQ_W-1:0]      i_req_type   = '0;
    logic [IDX_W-1:0]      i_flag_index = '0;
    logic                  i_cfg_we     = 1'b0;
    logic [MASK_W-1:0]     i_cfg_wdata  = '0;
    logic                  o_busy;
    logic                  o_strobe;
    logic                  o_accepted;
    logic                  o_flag_state;
    logic                  o_flag_enabled;
    logic [OUT_CNT_W-1:0]  o_flag_count;
    logic                  o_overall_active;
    logic [IDX_W-1:0]      o_overall_index;
    logic [OUT_CNT_W-1:0]  o_overall_count;

    // Typed expectation travelling with the request beat, driven like the inputs.
    bit                    drv_typed = 1'b0;
    t_registry_result      drv_want  = '0;

    // Predictor state.
    logic [MASK_W-1:0]     en_mask;
    logic                  flag_latched [ENTRIES];
    logic [OUT_CNT_W-1:0]  hit_count [ENTRIES];
    logic                  ovr_valid;
    logic [IDX_W-1:0]      ovr_src;

    t_registry_result      pending_results [$];
    t_plan_step            plan [$];
    int                    mismatches = 0;
    int                    beats_seen = 0;
    int                    cycle_count = 0;
    int                    idle_pct = 0;

    error_flag_registry_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_req_type       (i_req_type),
        .i_flag_index     (i_flag_index),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_strobe         (o_strobe),
        .o_accepted       (o_accepted),
        .o_flag_state     (o_flag_state),
        .o_flag_enabled   (o_flag_enabled),
        .o_flag_count     (o_flag_count),
        .o_overall_active (o_overall_active),
        .o_overall_index  (o_overall_index),
        .o_overall_count  (o_overall_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic void registry_clear();
        for (int k = 0; k < ENTRIES; k++) begin
            flag_latched[k] = 1'b0;
            hit_count[k]    = '0;
        end
        ovr_valid = 1'b0;
        ovr_src   = '0;
    endfunction

    function automatic void bump_count(logic [IDX_W-1:0] k);
        if (hit_count[k] != {OUT_CNT_W{1'b1}})
            hit_count[k] = hit_count[k] + 1'b1;
    endfunction

    // Applies one request to the predicted registry and returns the beat it should produce.
    function automatic t_registry_result registry_apply(logic [REQ_W-1:0] req,
                                                         logic [IDX_W-1:0] idx);
        t_registry_result r;
        logic [IDX_W-1:0] lowest;
        bit               found;
        r      = '0;
        lowest = '0;
        found  = 1'b0;
        case (req)
            REQ_SET: begin
                if (idx != 0 && en_mask[0] && en_mask[idx] && !flag_latched[idx]) begin
                    flag_latched[idx] = 1'b1;
                    bump_count(idx);
                    if (!ovr_valid) begin
                        ovr_valid = 1'b1;
                        ovr_src   = idx;
                        bump_count('0);
                    end
                    r.accepted = 1'b1;
                end
            end
            REQ_CLEAR: begin
                if (idx != 0) begin
                    r.accepted = 1'b1;
                    if (flag_latched[idx]) begin
                        flag_latched[idx] = 1'b0;
                        for (int k = 1; k < ENTRIES; k++) begin
                            if (flag_latched[k] && !found) begin
                                lowest = IDX_W'(k);
                                found  = 1'b1;
                            end
                        end
                        if (!found) begin
                            ovr_valid = 1'b0;
                            ovr_src   = '0;
                        end else if (!ovr_valid || ovr_src != lowest) begin
                            ovr_valid = 1'b1;
                            ovr_src   = lowest;
                            bump_count('0);
                        end
                    end
                end
            end
            REQ_REINIT: begin
                registry_clear();
                r.accepted = 1'b1;
            end
            default: r.accepted = 1'b1;
        endcase
        r.state     = (idx == 0) ? ovr_valid : flag_latched[idx];
        r.enabled   = en_mask[idx];
        r.count     = hit_count[idx];
        r.ov_active = ovr_valid;
        r.ov_index  = ovr_src;
        r.ov_count  = hit_count[0];
        return r;
    endfunction

    function automatic t_registry_result outcome(int acc, int st, int en, int cnt,
                                                 int oa, int oi, int oc);
        return {acc[0], st[0], en[0], cnt[OUT_CNT_W-1:0], oa[0], oi[IDX_W-1:0],
                oc[OUT_CNT_W-1:0]};
    endfunction

    task automatic flag_mismatch(string msg);
        $display("[%0t] beat %0d mismatch: %s", $time, beats_seen, msg);
        mismatches++;
    endtask

    task automatic check_beat(t_registry_result got, t_registry_result want);
        if (got.accepted !== want.accepted)
            flag_mismatch($sformatf("accepted %b, expected %b", got.accepted, want.accepted));
        if (got.state !== want.state)
            flag_mismatch($sformatf("flag_state %b, expected %b", got.state, want.state));
        if (got.enabled !== want.enabled)
            flag_mismatch($sformatf("flag_enabled %b, expected %b", got.enabled, want.enabled));
        if (got.count !== want.count)
            flag_mismatch($sformatf("flag_count %0d, expected %0d", got.count, want.count));
        if (got.ov_active !== want.ov_active)
            flag_mismatch($sformatf("overall_active %b, expected %b",
                                    got.ov_active, want.ov_active));
        if (got.ov_index !== want.ov_index)
            flag_mismatch($sformatf("overall_index %0d, expected %0d",
                                    got.ov_index, want.ov_index));
        if (got.ov_count !== want.ov_count)
            flag_mismatch($sformatf("overall_count %0d, expected %0d",
                                    got.ov_count, want.ov_count));
    endtask

    // Monitor: the result beat is retired before the new request is predicted, since a
    // strobe at the same edge always belongs to an older request.
    always @(posedge i_clk) begin
        t_registry_result want;
        t_registry_result got;
        if (!i_rst_n) begin
            en_mask = {MASK_W{1'b1}};
            registry_clear();
        end else begin
            if (i_cfg_we)
                en_mask = i_cfg_wdata;
            if (o_strobe) begin
                got = {o_accepted, o_flag_state, o_flag_enabled, o_flag_count,
                       o_overall_active, o_overall_index, o_overall_count};
                if (pending_results.size() == 0)
                    flag_mismatch("result beat with nothing pending");
                else
                    check_beat(got, pending_results.pop_front());
                beats_seen++;
            end
            if (i_start && !o_busy) begin
                want = registry_apply(i_req_type, i_flag_index);
                if (drv_typed)
                    want = drv_want;
                pending_results.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d results pending", $time, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                                bit typed, t_registry_result want);
        // Each cycle ahead of the beat is left idle with the chance that idle_pct gives.
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_req_type   <= req;
        i_flag_index <= idx;
        drv_typed    <= typed;
        drv_want     <= want;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mask(logic [MASK_W-1:0] m);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic add_req(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx);
        plan.push_back('{1'b0, '0, req, idx, 1'b0, '0});
    endtask

    task automatic add_typed(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                             t_registry_result want);
        plan.push_back('{1'b0, '0, req, idx, 1'b1, want});
    endtask

    task automatic add_cfg(logic [MASK_W-1:0] m);
        plan.push_back('{1'b1, m, '0, '0, 1'b0, '0});
    endtask

    initial begin
        t_plan_step       step;
        logic [REQ_W-1:0] req;
        logic [MASK_W-1:0] m;
        int               pick;

        // Directed plan from reset: entry 0 handling, re-set of a latched flag, overall
        // hand-over on clear, clear of an unlatched flag, reinit, and the enable gating.
        add_typed(REQ_QUERY,  4'd0,  outcome(1, 0, 1, 0, 0, 0, 0));
        add_typed(REQ_SET,    4'd0,  outcome(0, 0, 1, 0, 0, 0, 0));
        add_typed(REQ_SET,    4'd1,  outcome(1, 1, 1, 1, 1, 1, 1));
        add_typed(REQ_SET,    4'd1,  outcome(0, 1, 1, 1, 1, 1, 1));
        add_typed(REQ_SET,    4'd5,  outcome(1, 1, 1, 1, 1, 1, 1));
        add_typed(REQ_CLEAR,  4'd1,  outcome(1, 0, 1, 1, 1, 5, 2));
        add_typed(REQ_CLEAR,  4'd0,  outcome(0, 1, 1, 2, 1, 5, 2));
        add_typed(REQ_QUERY,  4'd15, outcome(1, 0, 1, 0, 1, 5, 2));
        add_typed(REQ_CLEAR,  4'd5,  outcome(1, 0, 1, 1, 0, 0, 2));
        add_typed(REQ_CLEAR,  4'd5,  outcome(1, 0, 1, 1, 0, 0, 2));
        add_typed(REQ_SET,    4'd15, outcome(1, 1, 1, 1, 1, 15, 3));
        add_req(REQ_SET,   4'd10);
        add_req(REQ_CLEAR, 4'd15);
        add_typed(REQ_REINIT, 4'd15, outcome(1, 0, 1, 0, 0, 0, 0));
        add_typed(REQ_QUERY,  4'd10, outcome(1, 0, 1, 0, 0, 0, 0));
        add_cfg(16'hFFFE);
        add_typed(REQ_SET,    4'd3,  outcome(0, 0, 1, 0, 0, 0, 0));
        add_typed(REQ_QUERY,  4'd0,  outcome(1, 0, 0, 0, 0, 0, 0));
        add_cfg(16'hFFF7);
        add_typed(REQ_SET,    4'd3,  outcome(0, 0, 0, 0, 0, 0, 0));
        add_typed(REQ_SET,    4'd2,  outcome(1, 1, 1, 1, 1, 2, 1));
        add_req(REQ_SET,   4'd12);
        add_typed(REQ_REINIT, 4'd0,  outcome(1, 0, 1, 0, 0, 0, 0));
        add_cfg(16'h0000);
        add_typed(REQ_SET,    4'd7,  outcome(0, 0, 0, 0, 0, 0, 0));
        add_typed(REQ_QUERY,  4'd9,  outcome(1, 0, 0, 0, 0, 0, 0));
        add_cfg(16'hFFFF);
        add_req(REQ_SET,   4'd7);
        add_typed(REQ_REINIT, 4'd7,  outcome(1, 0, 1, 0, 0, 0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 25;
        foreach (plan[n]) begin
            step = plan[n];
            if (step.is_cfg)
                write_mask(step.mask);
            else
                send_request(step.req, step.idx, step.typed, step.want);
        end

        // Random traffic in six segments: two per idling profile, a new mask for each.
        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0, 3:    m = 16'hFFFF;
                5:       m = MASK_W'($urandom_range(0, 16'hFFFF));
                default: m = MASK_W'($urandom_range(0, 16'hFFFF)) | 16'h0001;
            endcase
            write_mask(m);
            idle_pct = (seg < 2) ? 25 : (seg < 4) ? 88 : 0;
            for (int n = 0; n < SEG_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    req = REQ_SET;
                else if (pick < 75)
                    req = REQ_CLEAR;
                else if (pick < 97)
                    req = REQ_QUERY;
                else
                    req = REQ_REINIT;
                send_request(req, IDX_W'($urandom_range(0, ENTRIES - 1)), 1'b0, '0);
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
